// ===== rtl/roll_pitch_yaw_to_rotation_matrix_top_defines.svh =====
// Assertion macros for the roll-pitch-yaw to rotation matrix block
`ifndef ROLL_PITCH_YAW_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define ROLL_PITCH_YAW_TO_ROTATION_MATRIX_TOP_DEFINES_SVH

// condition implies consequence on the next clock edge
`define RPY_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

// condition implies consequence on the same clock edge
`define RPY_ASSERT_NOW(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/rpy_rot_pkg.sv =====
// Types and constants shared by the roll-pitch-yaw rotation matrix block
package rpy_rot_pkg;

    localparam int ANGLE_W = 16;
    localparam int Q_W     = 34;   // internal Q30 width, covers +-8
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [Q_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [Q_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [Q_W-1:0] Q30_GAIN    = 34'sd652032874;

    // one CORDIC lane: x, y, residual angle, quadrant flip
    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic                  flip;
    } lane_t;

    // three lanes carried together down the chain of cells
    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
    } trio_t;

    function automatic logic signed [Q_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Q_W-1:0] r;
        begin
            case (idx)
                5'd0:  r = 34'sh3243F6A8;
                5'd1:  r = 34'sh1DAC6705;
                5'd2:  r = 34'sh0FADBAFC;
                5'd3:  r = 34'sh07F56EA6;
                5'd4:  r = 34'sh03FEAB76;
                5'd5:  r = 34'sh01FFD55B;
                5'd6:  r = 34'sh00FFFAAA;
                5'd7:  r = 34'sh007FFF55;
                5'd8:  r = 34'sh003FFFEA;
                5'd9:  r = 34'sh001FFFFD;
                5'd10: r = 34'sh000FFFFF;
                5'd11: r = 34'sh0007FFFF;
                5'd12: r = 34'sh0003FFFF;
                5'd13: r = 34'sh0001FFFF;
                5'd14: r = 34'sh0000FFFF;
                5'd15: r = 34'sh00007FFF;
                5'd16: r = 34'sh00003FFF;
                5'd17: r = 34'sh00001FFF;
                5'd18: r = 34'sh00000FFF;
                5'd19: r = 34'sh000007FF;
                5'd20: r = 34'sh000003FF;
                5'd21: r = 34'sh000001FF;
                5'd22: r = 34'sh000000FF;
                5'd23: r = 34'sh0000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Q30 product, round half up (floor of p + 2^29 over 2^30)
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            return Q_W'(p >>> 30);
        end
    endfunction

endpackage

// ===== rtl/rpy_rot_cell.sv =====
// One CORDIC rotation cell: advances three lanes by one micro-rotation
module rpy_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  rpy_rot_pkg::trio_t  in_data,
    output logic                out_valid,
    output rpy_rot_pkg::trio_t  out_data
);

    localparam logic signed [rpy_rot_pkg::Q_W-1:0] ATAN = rpy_rot_pkg::atan_q30(5'(STEP));

    logic               valid_reg;
    rpy_rot_pkg::trio_t data_reg;
    rpy_rot_pkg::trio_t data_next;

    function automatic rpy_rot_pkg::lane_t rotate(input rpy_rot_pkg::lane_t l);
        rpy_rot_pkg::lane_t r;
        begin
            r = l;
            if (!l.z[rpy_rot_pkg::Q_W-1]) begin
                r.x = l.x - (l.y >>> STEP);
                r.y = l.y + (l.x >>> STEP);
                r.z = l.z - ATAN;
            end else begin
                r.x = l.x + (l.y >>> STEP);
                r.y = l.y - (l.x >>> STEP);
                r.z = l.z + ATAN;
            end
            return r;
        end
    endfunction

    always_comb begin
        data_next.roll  = rotate(in_data.roll);
        data_next.pitch = rotate(in_data.pitch);
        data_next.yaw   = rotate(in_data.yaw);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rpy_rot_matrix.sv =====
// Matrix stages: quadrant flip, pair products, triple products and sums, rounding and clamp
module rpy_rot_matrix #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  rpy_rot_pkg::trio_t  in_data,
    output logic                out_valid,
    output logic [9*16-1:0]     out_data
);

    localparam int QW = rpy_rot_pkg::Q_W;
    localparam int SH = 30 - OUT_FRAC_BITS;

    typedef logic signed [QW-1:0] q_t;

    // stage 1: apply quadrant flip
    logic [2:0] valid_reg;
    q_t sa_reg, ca_reg, sb_reg, cb_reg, sy_reg, cy_reg;
    // stage 2: pair products
    q_t cbcy_reg, casy_reg, sasb_reg, sasy_reg, casb_reg, cbsy_reg;
    q_t cacy_reg, sacy_reg, cbsa_reg, cacb_reg, nsb_reg, cy2_reg, sy2_reg;
    // stage 3: triple products and sums
    q_t e_reg [9];
    // stage 4: output
    logic [9*16-1:0] out_reg;
    logic            ovalid_reg;

    function automatic logic [15:0] to_out(input q_t v);
        q_t r;
        q_t lim;
        begin
            lim = q_t'(1) <<< OUT_FRAC_BITS;
            if (SH > 0) begin
                r = (v + (q_t'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            end else begin
                r = v;
            end
            if (r > lim) begin
                r = lim;
            end
            if (r < -lim) begin
                r = -lim;
            end
            return r[15:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else if (en) begin
            valid_reg  <= {valid_reg[1:0], in_valid};
            ovalid_reg <= valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= in_data.roll.flip  ? -in_data.roll.y  : in_data.roll.y;
            ca_reg <= in_data.roll.flip  ? -in_data.roll.x  : in_data.roll.x;
            sb_reg <= in_data.pitch.flip ? -in_data.pitch.y : in_data.pitch.y;
            cb_reg <= in_data.pitch.flip ? -in_data.pitch.x : in_data.pitch.x;
            sy_reg <= in_data.yaw.flip   ? -in_data.yaw.y   : in_data.yaw.y;
            cy_reg <= in_data.yaw.flip   ? -in_data.yaw.x   : in_data.yaw.x;

            cbcy_reg <= rpy_rot_pkg::qmul(cb_reg, cy_reg);
            casy_reg <= rpy_rot_pkg::qmul(ca_reg, sy_reg);
            sasb_reg <= rpy_rot_pkg::qmul(sa_reg, sb_reg);
            sasy_reg <= rpy_rot_pkg::qmul(sa_reg, sy_reg);
            casb_reg <= rpy_rot_pkg::qmul(ca_reg, sb_reg);
            cbsy_reg <= rpy_rot_pkg::qmul(cb_reg, sy_reg);
            cacy_reg <= rpy_rot_pkg::qmul(ca_reg, cy_reg);
            sacy_reg <= rpy_rot_pkg::qmul(sa_reg, cy_reg);
            cbsa_reg <= rpy_rot_pkg::qmul(cb_reg, sa_reg);
            cacb_reg <= rpy_rot_pkg::qmul(ca_reg, cb_reg);
            nsb_reg  <= -sb_reg;
            cy2_reg  <= cy_reg;
            sy2_reg  <= sy_reg;

            e_reg[0] <= cbcy_reg;
            e_reg[1] <= -casy_reg + rpy_rot_pkg::qmul(sasb_reg, cy2_reg);
            e_reg[2] <= sasy_reg + rpy_rot_pkg::qmul(casb_reg, cy2_reg);
            e_reg[3] <= cbsy_reg;
            e_reg[4] <= cacy_reg + rpy_rot_pkg::qmul(sasb_reg, sy2_reg);
            e_reg[5] <= -sacy_reg + rpy_rot_pkg::qmul(casb_reg, sy2_reg);
            e_reg[6] <= nsb_reg;
            e_reg[7] <= cbsa_reg;
            e_reg[8] <= cacb_reg;

            for (int i = 0; i < 9; i++) begin
                out_reg[i*16 +: 16] <= to_out(e_reg[i]);
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/roll_pitch_yaw_to_rotation_matrix_top.sv =====
// Top level: angle fold, CORDIC cell chain, matrix stages
//
// Streams angle triples in on the s_ channel and rotation matrices out on m_.
// s_axis_tdata: roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32],
// each signed Q2.13 radians. m_axis_tdata: m00..m22 row by row, 16 bits each,
// signed Q1.14 (OUT_FRAC_BITS fraction bits), m00 in the lowest bits.
// Path from accepted input word to output word: one fold register, one cell per
// CORDIC step, four matrix stages; every stage is a register in the chain.
// Throughput: one word per cycle while the output is not stalled.
// When m_axis_tready is low with a word waiting at the output, the whole chain
// holds and s_axis_tready drops; bubbles inside the chain are not squeezed out.
// Reset clears every valid bit; data registers are not reset.
`include "roll_pitch_yaw_to_rotation_matrix_top_defines.svh"
module roll_pitch_yaw_to_rotation_matrix_top #(
    parameter int CORDIC_STEPS  = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

    localparam int QW = rpy_rot_pkg::Q_W;

    logic en;
    logic fold_valid_reg;
    rpy_rot_pkg::trio_t fold_reg;
    rpy_rot_pkg::trio_t fold_next;

    logic               chain_valid [CORDIC_STEPS+1];
    rpy_rot_pkg::trio_t chain_data  [CORDIC_STEPS+1];

    // pipeline advances unless a finished word sits unaccepted at the output
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    function automatic rpy_rot_pkg::lane_t fold(input logic [15:0] a);
        rpy_rot_pkg::lane_t l;
        logic signed [QW-1:0] z;
        begin
            z      = QW'($signed(a)) <<< 17;
            l.x    = rpy_rot_pkg::Q30_GAIN;
            l.y    = '0;
            l.flip = 1'b0;
            l.z    = z;
            if (z > rpy_rot_pkg::Q30_HALF_PI) begin
                l.z    = z - rpy_rot_pkg::Q30_PI;
                l.flip = 1'b1;
            end else if (z < -rpy_rot_pkg::Q30_HALF_PI) begin
                l.z    = z + rpy_rot_pkg::Q30_PI;
                l.flip = 1'b1;
            end
            return l;
        end
    endfunction

    always_comb begin
        fold_next.roll  = fold(s_axis_tdata[15:0]);
        fold_next.pitch = fold(s_axis_tdata[31:16]);
        fold_next.yaw   = fold(s_axis_tdata[47:32]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (en) begin
            fold_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
        end
    end

    assign chain_valid[0] = fold_valid_reg;
    assign chain_data[0]  = fold_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rpy_rot_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    rpy_rot_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_data   (chain_data[CORDIC_STEPS]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    `RPY_ASSERT_NEXT(a_hold_stall, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata),
        "output word changed while stalled")
    `RPY_ASSERT_NOW(a_ready_rule, aclk, aresetn, !m_axis_tvalid, s_axis_tready,
        "input stalled with empty output")
    `RPY_ASSERT_NEXT(a_fold_capture, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        fold_valid_reg, "accepted word not captured")

endmodule
